// File: hw/rtl/nssc_pkg.sv
package nssc_pkg;

	localparam int BYTE_W  = 8;
	localparam int NAME_W  = 5;
	localparam int COUNT_W = 12;
	localparam int CMD_W   = 2;

	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int RES_QUEUE_DEPTH = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REDEF  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_REDEF,
		OP_CLEAR,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		ST_EXEC,
		ST_DEL,
		ST_MOVE
	} back_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] char_byte;
		logic [NAME_W-1:0] name_index;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] stored_bytes;
		logic [COUNT_W-1:0] free_bytes;
		logic [NAME_W-1:0]  selected_name;
		logic [COUNT_W-1:0] selected_length;
		logic               byte_dropped;
	} out_item_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] char_byte;
		logic [NAME_W-1:0] name;
	} cmd_t;

endpackage

// File: hw/rtl/nssc_fifo.sv
module nssc_fifo #(
	parameter int DEPTH = 2,
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	output logic full,
	input  T     din,
	input  logic rd,
	output logic empty,
	output T     dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T               data_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = data_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			data_q[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/nssc_front.sv
module nssc_front #(
	parameter int NAME_COUNT = 26
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  nssc_pkg::in_item_t request,
	input  logic               cmd_pop,
	output logic               cmd_valid,
	output nssc_pkg::cmd_t     cmd
);

	nssc_pkg::cmd_t cls;
	logic           cmd_empty;

	always_comb begin
		cls.char_byte = request.char_byte;
		cls.name      = request.name_index;
		unique case (request.command)
			nssc_pkg::CMD_APPEND: cls.op = nssc_pkg::OP_APPEND;
			nssc_pkg::CMD_REDEF:
				cls.op = (int'(request.name_index) < NAME_COUNT) ?
					nssc_pkg::OP_REDEF : nssc_pkg::OP_NONE;
			nssc_pkg::CMD_CLEAR:  cls.op = nssc_pkg::OP_CLEAR;
			default:              cls.op = nssc_pkg::OP_NONE;
		endcase
	end

	nssc_fifo #(
		.DEPTH(nssc_pkg::CMD_QUEUE_DEPTH),
		.T(nssc_pkg::cmd_t)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.full  (full),
		.din   (cls),
		.rd    (cmd_pop),
		.empty (cmd_empty),
		.dout  (cmd)
	);

	assign cmd_valid = !cmd_empty;

endmodule

// File: hw/rtl/nssc_back.sv
module nssc_back #(
	parameter int MEM_BYTES  = 2048,
	parameter int NAME_COUNT = 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  nssc_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  logic                res_full,
	output logic                res_push,
	output nssc_pkg::out_item_t res
);

	localparam int AW  = $clog2(MEM_BYTES + 1);
	localparam int MA  = $clog2(MEM_BYTES);
	localparam int NIW = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
	localparam int CW  = nssc_pkg::COUNT_W;
	localparam int NW  = nssc_pkg::NAME_W;

	nssc_pkg::back_state_t state_q, state_d;

	logic [7:0]     mem [MEM_BYTES];
	logic [7:0]     rdata_s1;
	logic           rd_v_s1;

	logic [AW-1:0]  len_q   [NAME_COUNT];
	logic [AW-1:0]  start_q [NAME_COUNT];
	logic [AW-1:0]  total_q;
	logic [AW-1:0]  sel_len_q;
	logic [NIW-1:0] cur_q;

	logic [AW-1:0]  del_start_q;
	logic [AW-1:0]  del_len_q;
	logic [NIW-1:0] del_name_q;
	logic [AW-1:0]  src_q;
	logic [AW-1:0]  dst_q;
	logic [AW-1:0]  end_q;

	logic [NIW-1:0] vname;
	logic [AW-1:0]  vstart;
	logic [AW-1:0]  vlen;
	logic [AW-1:0]  clip_start;
	logic [AW-1:0]  clip_rem;
	logic [AW-1:0]  clip_len;
	logic           victim_nz;
	logic           room;

	logic do_append, do_select, do_capture, do_clear, do_del;
	logic move_rd, move_done;

	logic [AW-1:0]  total_n;
	logic [AW-1:0]  sel_n;
	logic [NIW-1:0] cur_n;
	logic           dropped;

	logic           mem_we;
	logic [MA-1:0]  mem_waddr;
	logic [7:0]     mem_wdata;

	assign vname      = NIW'(cmd.name);
	assign vstart     = start_q[vname];
	assign vlen       = len_q[vname];
	assign victim_nz  = (vlen != '0);
	assign clip_start = (vstart > total_q) ? total_q : vstart;
	assign clip_rem   = total_q - clip_start;
	assign clip_len   = (vlen > clip_rem) ? clip_rem : vlen;
	assign room       = (total_q != AW'(MEM_BYTES));

	assign move_rd   = (state_q == nssc_pkg::ST_MOVE) && (src_q != end_q);
	assign move_done = (state_q == nssc_pkg::ST_MOVE) && !move_rd && !rd_v_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nssc_pkg::ST_EXEC:
				if (cmd_valid && !res_full && cmd.op == nssc_pkg::OP_REDEF && victim_nz)
					state_d = nssc_pkg::ST_DEL;
			nssc_pkg::ST_DEL:
				if (!res_full)
					state_d = nssc_pkg::ST_MOVE;
			nssc_pkg::ST_MOVE:
				if (move_done)
					state_d = nssc_pkg::ST_EXEC;
			default: state_d = nssc_pkg::ST_EXEC;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		do_append  = 1'b0;
		do_select  = 1'b0;
		do_capture = 1'b0;
		do_clear   = 1'b0;
		do_del     = 1'b0;
		unique case (state_q)
			nssc_pkg::ST_EXEC:
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						nssc_pkg::OP_APPEND: begin
							do_append = 1'b1;
							res_push  = 1'b1;
						end
						nssc_pkg::OP_REDEF: begin
							if (victim_nz)
								do_capture = 1'b1;
							else begin
								do_select = 1'b1;
								res_push  = 1'b1;
							end
						end
						nssc_pkg::OP_CLEAR: begin
							do_clear = 1'b1;
							res_push = 1'b1;
						end
						nssc_pkg::OP_NONE: res_push = 1'b1;
					endcase
				end
			nssc_pkg::ST_DEL:
				if (!res_full) begin
					do_del   = 1'b1;
					res_push = 1'b1;
				end
			nssc_pkg::ST_MOVE: ;
			default: ;
		endcase
	end

	always_comb begin
		total_n = total_q;
		sel_n   = sel_len_q;
		cur_n   = cur_q;
		dropped = 1'b0;
		if (do_append) begin
			if (room) begin
				total_n = total_q + 1'b1;
				sel_n   = sel_len_q + 1'b1;
			end else
				dropped = 1'b1;
		end
		if (do_select) begin
			cur_n = vname;
			sel_n = '0;
		end
		if (do_clear) begin
			total_n = '0;
			cur_n   = '0;
			sel_n   = '0;
		end
		if (do_del) begin
			total_n = total_q - del_len_q;
			cur_n   = del_name_q;
			sel_n   = '0;
		end
	end

	always_comb begin
		res.stored_bytes    = CW'(total_n);
		res.free_bytes      = CW'(AW'(MEM_BYTES) - total_n);
		res.selected_name   = NW'(cur_n);
		res.selected_length = CW'(sel_n);
		res.byte_dropped    = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nssc_pkg::ST_EXEC;
			total_q   <= '0;
			sel_len_q <= '0;
			cur_q     <= '0;
			rd_v_s1   <= 1'b0;
			for (int i = 0; i < NAME_COUNT; i++) begin
				len_q[i]   <= '0;
				start_q[i] <= '0;
			end
		end else begin
			state_q   <= state_d;
			total_q   <= total_n;
			sel_len_q <= sel_n;
			cur_q     <= cur_n;
			rd_v_s1   <= move_rd;
			if (do_append && room)
				len_q[cur_q] <= sel_len_q + 1'b1;
			if (do_select)
				start_q[vname] <= total_q;
			if (do_clear) begin
				for (int i = 0; i < NAME_COUNT; i++) begin
					len_q[i]   <= '0;
					start_q[i] <= '0;
				end
			end
			if (do_del) begin
				for (int i = 0; i < NAME_COUNT; i++) begin
					if (len_q[i] != '0 && start_q[i] > del_start_q)
						start_q[i] <= (start_q[i] >= del_len_q) ?
							start_q[i] - del_len_q : '0;
				end
				start_q[del_name_q] <= total_q - del_len_q;
				len_q[del_name_q]   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_capture) begin
			del_start_q <= clip_start;
			del_len_q   <= clip_len;
			del_name_q  <= vname;
		end
		if (do_del) begin
			src_q <= del_start_q + del_len_q;
			dst_q <= del_start_q;
			end_q <= total_q;
		end else begin
			if (move_rd)
				src_q <= src_q + 1'b1;
			if (rd_v_s1)
				dst_q <= dst_q + 1'b1;
		end
	end

	// compaction: read at src, write at dst in the cycle after
	assign mem_we    = (do_append && room) || rd_v_s1;
	assign mem_waddr = rd_v_s1 ? MA'(dst_q) : MA'(total_q);
	assign mem_wdata = rd_v_s1 ? rdata_s1 : cmd.char_byte;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_s1 <= mem[MA'(src_q)];
	end

endmodule

// File: hw/rtl/named_string_store_compactor.sv
// An append, clear or plain select reaches the result ports through the command queue
// register and the result queue register. A redefine of a non-empty name reports from
// its deletion state, then the byte memory's read and write ports move each byte after
// the deleted string down (none when no bytes follow it). Throughput: 1 item per cycle
// for appends, clears and selects while the result queue has room; a deletion blocks
// the back end for the compaction, while the command queue still takes items until full.
// Reset (arst_n, async low): empties both queues, zeroes all lengths, starts and totals.
module named_string_store_compactor #(
	parameter int MEM_BYTES  = 2048,
	parameter int NAME_COUNT = 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  nssc_pkg::in_item_t  request,
	output logic                empty,
	input  logic                pop,
	output nssc_pkg::out_item_t result
);

	nssc_pkg::cmd_t      cmd;
	nssc_pkg::out_item_t res;
	logic                cmd_valid;
	logic                cmd_pop;
	logic                res_full;
	logic                res_push;

	nssc_front #(
		.NAME_COUNT(NAME_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.cmd_pop  (cmd_pop),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	nssc_back #(
		.MEM_BYTES (MEM_BYTES),
		.NAME_COUNT(NAME_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	nssc_fifo #(
		.DEPTH(nssc_pkg::RES_QUEUE_DEPTH),
		.T(nssc_pkg::out_item_t)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.full  (res_full),
		.din   (res),
		.rd    (pop),
		.empty (empty),
		.dout  (result)
	);

endmodule

// File: bench/tb_named_string_store_compactor.sv
`timescale 1ns / 100ps

module tb_named_string_store_compactor;

	localparam int MEM_BYTES    = 2048;
	localparam int NAME_COUNT   = 26;
	localparam int RANDOM_ITEMS = 600;
	localparam int DRAIN_CYCLES = MEM_BYTES + 16;
	localparam int CMD_W        = nssc_pkg::CMD_W;
	localparam int BYTE_W       = nssc_pkg::BYTE_W;
	localparam int NAME_W       = nssc_pkg::NAME_W;
	localparam int COUNT_W      = nssc_pkg::COUNT_W;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                push    = 1'b0;
	logic                pop     = 1'b0;
	nssc_pkg::in_item_t  request = '0;
	logic                full;
	logic                empty;
	nssc_pkg::out_item_t result;

	named_string_store_compactor #(
		.MEM_BYTES (MEM_BYTES),
		.NAME_COUNT(NAME_COUNT)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	// store model
	int str_len [NAME_COUNT];
	int str_start [NAME_COUNT];
	int stored_total;
	int cur_name;
	nssc_pkg::out_item_t pending_totals[$];

	bit tx_burst;
	bit rx_burst;
	int rx_hold_cycles;

	int fail_count;
	int n_appends;
	int n_dropped;
	int n_redefs;
	int n_compactions;
	int n_clears;
	int n_ignored;
	int n_checked;
	int n_stall_cycles;

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic void delete_string(int victim);
		int s;
		int l;
		s = str_start[victim];
		l = str_len[victim];
		if (s > stored_total)
			s = stored_total;
		if (l > stored_total - s)
			l = stored_total - s;
		for (int i = 0; i < NAME_COUNT; i++) begin
			if (str_len[i] != 0 && str_start[i] > s)
				str_start[i] = (str_start[i] >= l) ? str_start[i] - l : 0;
		end
		stored_total -= l;
		str_len[victim] = 0;
	endfunction

	function automatic nssc_pkg::out_item_t apply_command(nssc_pkg::in_item_t it);
		nssc_pkg::out_item_t r;
		r = '0;
		case (it.command)
			nssc_pkg::CMD_APPEND: begin
				n_appends++;
				if (stored_total < MEM_BYTES) begin
					stored_total++;
					str_len[cur_name]++;
				end else begin
					r.byte_dropped = 1'b1;
					n_dropped++;
				end
			end
			nssc_pkg::CMD_REDEF: begin
				if (it.name_index < NAME_COUNT) begin
					n_redefs++;
					if (str_len[it.name_index] != 0) begin
						n_compactions++;
						delete_string(it.name_index);
					end
					cur_name = it.name_index;
					str_start[cur_name] = stored_total;
				end else begin
					n_ignored++;
				end
			end
			nssc_pkg::CMD_CLEAR: begin
				n_clears++;
				stored_total = 0;
				cur_name = 0;
				for (int i = 0; i < NAME_COUNT; i++) begin
					str_len[i] = 0;
					str_start[i] = 0;
				end
			end
			default: begin
				n_ignored++;
			end
		endcase
		r.stored_bytes    = COUNT_W'(stored_total);
		r.free_bytes      = COUNT_W'(MEM_BYTES - stored_total);
		r.selected_name   = NAME_W'(cur_name);
		r.selected_length = COUNT_W'(str_len[cur_name]);
		return r;
	endfunction

	task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] ch,
			logic [NAME_W-1:0] name);
		nssc_pkg::in_item_t it;
		int gap;
		it.command    = cmd;
		it.char_byte  = ch;
		it.name_index = name;
		gap = tx_burst ? 0 : idle_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		request <= it;
		do @(posedge clk); while (full);
		pending_totals.push_back(apply_command(it));
	endtask

	task automatic send_append();
		send_item(nssc_pkg::CMD_APPEND, BYTE_W'($urandom_range(0, 255)),
			NAME_W'($urandom_range(0, 31)));
	endtask

	task automatic send_redefine(int name);
		send_item(nssc_pkg::CMD_REDEF, BYTE_W'($urandom_range(0, 255)), NAME_W'(name));
	endtask

	task automatic stop_and_drain();
		push <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_item(nssc_pkg::CMD_APPEND, 8'h00, 5'd0);
		send_item(nssc_pkg::CMD_APPEND, 8'hFF, 5'd31);
		send_item(nssc_pkg::CMD_REDEF, 8'hFF, 5'd25);
		send_item(nssc_pkg::CMD_APPEND, 8'h5A, 5'd0);
		send_item(nssc_pkg::CMD_APPEND, 8'hA5, 5'd0);
		send_item(nssc_pkg::CMD_APPEND, 8'h01, 5'd0);
		send_item(nssc_pkg::CMD_REDEF, 8'h00, 5'd1);
		send_item(nssc_pkg::CMD_APPEND, 8'h80, 5'd0);
		send_item(nssc_pkg::CMD_APPEND, 8'h7F, 5'd0);
		// first string removed, later ones shift down
		send_item(nssc_pkg::CMD_REDEF, 8'h00, 5'd0);
		send_item(nssc_pkg::CMD_APPEND, 8'h11, 5'd0);
		// last string removed, nothing to move
		send_item(nssc_pkg::CMD_REDEF, 8'h00, 5'd0);
		send_item(nssc_pkg::CMD_REDEF, 8'h00, 5'd26);
		send_item(nssc_pkg::CMD_REDEF, 8'hFF, 5'd31);
		send_item(CMD_UNUSED, 8'hFF, 5'd31);
		// first string removed again, the next one shifts down
		send_item(nssc_pkg::CMD_REDEF, 8'h00, 5'd25);
		send_item(nssc_pkg::CMD_CLEAR, 8'hFF, 5'd31);
		send_item(nssc_pkg::CMD_APPEND, 8'h33, 5'd0);
		send_item(nssc_pkg::CMD_REDEF, 8'h00, 5'd0);
		send_item(nssc_pkg::CMD_CLEAR, 8'h00, 5'd0);
	endtask

	task automatic test_fill_to_capacity();
		int n;
		n = 0;
		send_item(nssc_pkg::CMD_CLEAR, 8'h00, 5'd0);
		while (stored_total < MEM_BYTES) begin
			if (n % 300 == 299)
				send_redefine(n / 300 + 1);
			else
				send_append();
			n++;
		end
		repeat (3) send_append();
		send_redefine(20);
		send_append();
		send_redefine(3);
		repeat (5) send_append();
		send_item(nssc_pkg::CMD_CLEAR, 8'hA5, 5'd17);
	endtask

	task automatic test_output_backpressure();
		rx_hold_cycles = 150;
		tx_burst = 1'b1;
		send_redefine(2);
		repeat (12) send_append();
		send_redefine(4);
		repeat (12) send_append();
		send_redefine(2);
		repeat (12) send_append();
		tx_burst = 1'b0;
	endtask

	task automatic test_random_traffic();
		int sent;
		int r;
		int run;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				tx_burst = ($urandom_range(0, 2) == 0);
				rx_burst = ($urandom_range(0, 2) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_item(nssc_pkg::CMD_CLEAR, BYTE_W'($urandom_range(0, 255)),
					NAME_W'($urandom_range(0, 31)));
				sent++;
			end else if (r < 9) begin
				if (r < 6)
					send_redefine($urandom_range(NAME_COUNT, 31));
				else
					send_item(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)),
						NAME_W'($urandom_range(0, 31)));
				sent++;
			end else if (r < 14) begin
				run = $urandom_range(1, 4);
				repeat (run) send_append();
				sent += run;
			end else begin
				send_redefine($urandom_range(0, NAME_COUNT - 1));
				run = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 16) :
					$urandom_range(17, 120);
				repeat (run) send_append();
				sent += run + 1;
			end
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	initial begin : result_drain
		int stall;
		stall = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (pop && !empty) begin
				stall = rx_burst ? 0 : idle_gap();
				pop <= (stall == 0);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : result_check
		nssc_pkg::out_item_t want;
		forever begin
			@(posedge clk);
			if (push && full)
				n_stall_cycles++;
			if (pop && !empty) begin
				if (pending_totals.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result at %0t: stored=%0d", $realtime,
							result.stored_bytes);
				end else begin
					want = pending_totals.pop_front();
					n_checked++;
					if (result.stored_bytes !== want.stored_bytes ||
							result.free_bytes !== want.free_bytes ||
							result.selected_name !== want.selected_name ||
							result.selected_length !== want.selected_length ||
							result.byte_dropped !== want.byte_dropped) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch at %0t: expected stored=%0d free=%0d name=%0d",
								" len=%0d drop=%0b, got stored=%0d free=%0d name=%0d",
								" len=%0d drop=%0b"}, $realtime,
								want.stored_bytes, want.free_bytes, want.selected_name,
								want.selected_length, want.byte_dropped,
								result.stored_bytes, result.free_bytes,
								result.selected_name, result.selected_length,
								result.byte_dropped);
					end
				end
			end
		end
	end

	initial begin : watchdog
		#400_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin : run_tests
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_fill_to_capacity();
		test_output_backpressure();
		test_random_traffic();
		stop_and_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d items: %0d appends (%0d dropped when full), %0d redefines",
			n_appends + n_redefs + n_clears + n_ignored, n_appends, n_dropped, n_redefs);
		$display("  (%0d compacting), %0d clears, %0d ignored; %0d results checked, %0d stalls",
			n_compactions, n_clears, n_ignored, n_checked, n_stall_cycles);
		if (fail_count == 0 && pending_totals.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
